// ----- hdl/urza_pkg.sv -----
// ----------------------------------------------------------------------------
// urza_pkg
// Shared types and constants of the ultrasonic range zone alarm unit.
// ----------------------------------------------------------------------------
package urza_pkg;

    typedef logic [2:0] zone_t;

    localparam zone_t ZONE_FAR        = 3'd0;
    localparam zone_t ZONE_MEDIUM     = 3'd1;
    localparam zone_t ZONE_CLOSE      = 3'd2;
    localparam zone_t ZONE_VERY_CLOSE = 3'd3;
    localparam zone_t ZONE_UNDEF      = 3'd4;

    typedef enum logic [2:0] {
        REG_TRIGGER_PERIOD   = 3'd0,
        REG_TRIGGER_WIDTH    = 3'd1,
        REG_ECHO_TIMEOUT     = 3'd2,
        REG_MIN_DISTANCE     = 3'd3,
        REG_LIMIT_VERY_CLOSE = 3'd4,
        REG_LIMIT_CLOSE      = 3'd5,
        REG_LIMIT_MEDIUM     = 3'd6,
        REG_ALARM_STEP       = 3'd7
    } reg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // floor(w * 1000 / 58824) == (w * DIST_RECIP) >> DIST_SHIFT for every 16-bit w
    localparam logic [23:0] DIST_RECIP = 24'd9126733;
    localparam int          DIST_SHIFT = 29;

    typedef struct packed {
        logic [23:0] trigger_period;
        logic [7:0]  trigger_width;
        logic [15:0] echo_timeout;
        logic [10:0] min_distance;
        logic [10:0] limit_very_close;
        logic [10:0] limit_close;
        logic [10:0] limit_medium;
        logic [21:0] alarm_step;
    } cfg_t;

    typedef struct packed {
        logic        new_measure;
        zone_t       zone;
        logic [10:0] distance_cm;
        logic        alarm;
        logic        trigger;
    } res_t;

endpackage

// ----- hdl/urza_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// urza_cfg_regs
// Configuration register file with reset defaults and indexed writes.
// ----------------------------------------------------------------------------
module urza_cfg_regs
    import urza_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx)
                REG_TRIGGER_PERIOD:   cfg_next.trigger_period   = cfg_wdata[23:0];
                REG_TRIGGER_WIDTH:    cfg_next.trigger_width    = cfg_wdata[7:0];
                REG_ECHO_TIMEOUT:     cfg_next.echo_timeout     = cfg_wdata[15:0];
                REG_MIN_DISTANCE:     cfg_next.min_distance     = cfg_wdata[10:0];
                REG_LIMIT_VERY_CLOSE: cfg_next.limit_very_close = cfg_wdata[10:0];
                REG_LIMIT_CLOSE:      cfg_next.limit_close      = cfg_wdata[10:0];
                REG_LIMIT_MEDIUM:     cfg_next.limit_medium     = cfg_wdata[10:0];
                REG_ALARM_STEP:       cfg_next.alarm_step       = cfg_wdata[21:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_period   <= 24'd100000;
            cfg_reg.trigger_width    <= 8'd2;
            cfg_reg.echo_timeout     <= 16'd40000;
            cfg_reg.min_distance     <= 11'd2;
            cfg_reg.limit_very_close <= 11'd10;
            cfg_reg.limit_close      <= 11'd25;
            cfg_reg.limit_medium     <= 11'd40;
            cfg_reg.alarm_step       <= 22'd50000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/urza_range_calc.sv -----
// ----------------------------------------------------------------------------
// urza_range_calc
// Echo width to distance in cm by reciprocal multiply, then zone lookup.
// ----------------------------------------------------------------------------
module urza_range_calc
    import urza_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [15:0] width,
    output logic [10:0] distance_cm,
    output zone_t       zone
);

    logic [39:0] prod;

    assign prod        = {24'd0, width} * {16'd0, DIST_RECIP};
    assign distance_cm = prod[DIST_SHIFT +: 11];

    always_comb begin
        if (distance_cm < cfg.min_distance) begin
            zone = ZONE_UNDEF;
        end else if (distance_cm < cfg.limit_very_close) begin
            zone = ZONE_VERY_CLOSE;
        end else if (distance_cm < cfg.limit_close) begin
            zone = ZONE_CLOSE;
        end else if (distance_cm < cfg.limit_medium) begin
            zone = ZONE_MEDIUM;
        end else begin
            zone = ZONE_FAR;
        end
    end

endmodule

// ----- hdl/urza_tick_core.sv -----
// ----------------------------------------------------------------------------
// urza_tick_core
// Per-tick state: trigger timing, alarm toggler and echo width measurement.
// ----------------------------------------------------------------------------
module urza_tick_core
    import urza_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  logic echo,
    input  cfg_t cfg,
    output res_t res
);

    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    logic [COUNT_BITS-1:0] period_count_reg, period_count_next;
    logic [COUNT_BITS-1:0] alarm_count_reg, alarm_count_next;
    logic [7:0]            trigger_left_reg, trigger_left_next;
    logic                  echo_prev_reg, echo_prev_next;
    logic                  measuring_reg, measuring_next;
    logic [15:0]           echo_count_reg, echo_count_next;
    logic [10:0]           last_distance_reg, last_distance_next;
    zone_t                 current_zone_reg, current_zone_next;
    logic                  alarm_running_reg, alarm_running_next;
    logic                  alarm_level_reg, alarm_level_next;

    logic [7:0]            trig_left_now;
    logic                  trig;
    logic [31:0]           last_tick_wide;
    logic [31:0]           last_tick_cap;
    logic [COUNT_BITS-1:0] last_tick;
    logic [23:0]           half_raw;
    logic [31:0]           half_cap;
    logic [COUNT_BITS-1:0] half;
    logic [COUNT_BITS-1:0] alarm_inc;
    logic [15:0]           echo_inc;
    logic                  finish;
    logic [15:0]           fin_width;
    logic [10:0]           calc_distance;
    zone_t                 calc_zone;

    urza_range_calc u_range_calc (
        .cfg         (cfg),
        .width       (fin_width),
        .distance_cm (calc_distance),
        .zone        (calc_zone)
    );

    // trigger
    always_comb begin
        trig_left_now     = (period_count_reg == '0) ? cfg.trigger_width : trigger_left_reg;
        trig              = trig_left_now != 8'd0;
        trigger_left_next = trig ? trig_left_now - 8'd1 : trig_left_now;
        last_tick_wide    = (cfg.trigger_period == 24'd0) ? 32'd0
                                                          : {8'd0, cfg.trigger_period - 24'd1};
        last_tick_cap     = (last_tick_wide > CNT_MAX) ? CNT_MAX : last_tick_wide;
        last_tick         = last_tick_cap[COUNT_BITS-1:0];
        period_count_next = (period_count_reg >= last_tick) ? '0
                                                            : period_count_reg + COUNT_BITS'(1);
    end

    // half-period = alarm_step * (4 - zone)
    always_comb begin
        case (current_zone_reg)
            ZONE_VERY_CLOSE: half_raw = {2'd0, cfg.alarm_step};
            ZONE_CLOSE:      half_raw = {1'd0, cfg.alarm_step, 1'd0};
            ZONE_MEDIUM:     half_raw = {2'd0, cfg.alarm_step} + {1'd0, cfg.alarm_step, 1'd0};
            ZONE_FAR:        half_raw = {cfg.alarm_step, 2'd0};
            default:         half_raw = 24'd0;
        endcase
        half_cap  = ({8'd0, half_raw} > CNT_MAX) ? CNT_MAX : {8'd0, half_raw};
        half      = half_cap[COUNT_BITS-1:0];
        alarm_inc = alarm_count_reg + COUNT_BITS'(1);
    end

    always_comb begin
        alarm_count_next   = alarm_count_reg;
        alarm_level_next   = alarm_level_reg;
        alarm_running_next = alarm_running_reg;
        current_zone_next  = current_zone_reg;
        last_distance_next = last_distance_reg;
        measuring_next     = measuring_reg;
        echo_count_next    = echo_count_reg;
        echo_prev_next     = echo;
        echo_inc           = (echo_count_reg != 16'hFFFF) ? echo_count_reg + 16'd1
                                                          : echo_count_reg;
        finish             = 1'b0;
        fin_width          = echo_count_reg;

        // toggle alarm
        if (alarm_running_reg && (current_zone_reg < ZONE_UNDEF)) begin
            if (alarm_inc >= half) begin
                alarm_level_next = ~alarm_level_reg;
                alarm_count_next = '0;
            end else begin
                alarm_count_next = alarm_inc;
            end
        end

        // measure echo
        if (measuring_reg) begin
            if (echo) begin
                if (echo_inc >= cfg.echo_timeout) begin
                    echo_count_next = cfg.echo_timeout;
                    fin_width       = cfg.echo_timeout;
                    finish          = 1'b1;
                end else begin
                    echo_count_next = echo_inc;
                end
            end else begin
                fin_width = echo_count_reg;
                finish    = 1'b1;
            end
        end else if (echo && !echo_prev_reg) begin
            measuring_next  = 1'b1;
            echo_count_next = 16'd1;
            if (cfg.echo_timeout <= 16'd1) begin
                echo_count_next = cfg.echo_timeout;
                fin_width       = cfg.echo_timeout;
                finish          = 1'b1;
            end
        end

        // close the reading and latch the distance; restart alarm on zone change
        if (finish) begin
            measuring_next     = 1'b0;
            last_distance_next = calc_distance;
            if (calc_zone != current_zone_reg) begin
                current_zone_next = calc_zone;
                if (calc_zone == ZONE_UNDEF) begin
                    alarm_running_next = 1'b0;
                end else begin
                    alarm_running_next = 1'b1;
                    alarm_count_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg  <= '0;
            alarm_count_reg   <= '0;
            trigger_left_reg  <= 8'd0;
            echo_prev_reg     <= 1'b0;
            measuring_reg     <= 1'b0;
            echo_count_reg    <= 16'd0;
            last_distance_reg <= 11'd0;
            current_zone_reg  <= ZONE_UNDEF;
            alarm_running_reg <= 1'b0;
            alarm_level_reg   <= 1'b1;
        end else if (advance) begin
            period_count_reg  <= period_count_next;
            alarm_count_reg   <= alarm_count_next;
            trigger_left_reg  <= trigger_left_next;
            echo_prev_reg     <= echo_prev_next;
            measuring_reg     <= measuring_next;
            echo_count_reg    <= echo_count_next;
            last_distance_reg <= last_distance_next;
            current_zone_reg  <= current_zone_next;
            alarm_running_reg <= alarm_running_next;
            alarm_level_reg   <= alarm_level_next;
        end
    end

    assign res.trigger     = trig;
    assign res.alarm       = alarm_level_next;
    assign res.distance_cm = last_distance_next;
    assign res.zone        = current_zone_next;
    assign res.new_measure = finish;

    a_running_needs_zone: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_running_reg |-> (current_zone_reg != ZONE_UNDEF))
        else $error("alarm toggler running in undefined zone");

    a_measuring_echo_high: assert property (@(posedge aclk) disable iff (!aresetn)
        measuring_reg |-> echo_prev_reg)
        else $error("measurement open while last echo sample was low");

    a_finish_clears_measuring: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && finish) |=> !measuring_reg)
        else $error("measurement still open after it finished");

endmodule

// ----- hdl/ultrasonic_range_zone_alarm_unit.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_range_zone_alarm_unit
// Ultrasonic echo range finder with zone classification and proximity alarm.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the s_ channel is one microsecond tick carrying the sampled
//   echo level. Every accepted tick yields exactly one word on the m_ channel
//   with the trigger level, alarm level, last distance, zone and a flag that
//   marks ticks where a measurement completed.
//   Configuration is written through cfg_we/cfg_idx/cfg_wdata while the unit
//   is idle; a write takes effect at the next clock edge.
//   An accepted tick passes the input register, then the result register.
//   Throughput: one tick per cycle while the result is not stalled, set by
//   the single combinational stage between the two registers, which holds
//   the whole tick update including the 16x24 distance multiply.
//   Reset (aresetn low, synchronous) restores the register defaults, clears
//   all counters, sets the zone to undefined and the alarm level to one.
//   When m_tready is low the result word holds, an empty input register
//   takes one more tick, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module ultrasonic_range_zone_alarm_unit
    import urza_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] echo
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [0] trigger, [1] alarm,
                                             // [12:2] distance_cm, [15:13] zone,
                                             // [16] new_measure
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg;
    res_t res;

    logic in_valid_reg, in_valid_next;
    logic in_echo_reg;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;
    logic advance;
    logic s_fire;

    urza_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    urza_tick_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tick_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .echo    (in_echo_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_echo_reg <= s_tdata[0];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg};

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed tick did not reach the result register");

endmodule

// ----- verif/tb_ultrasonic_range_zone_alarm_unit.sv -----
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_zone_alarm_unit
// Self-checking bench for the ultrasonic range zone alarm unit. Echo ticks go
// in on the s_ stream. A cycle-true model of the trigger generator, the echo
// width counter, the distance and zone logic and the alarm toggler predicts
// every result word. The checker compares each m_ word field by field with
// the oldest prediction. Reset-default ticks come first, then directed corner
// settings, then a long echo held past the timeout, then random register
// settings with pulse-shaped echo traffic. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_zone_alarm_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import urza_pkg::*;

    localparam int              CNT_W         = 24;
    localparam longint unsigned CNT_MAX       = (64'd1 << CNT_W) - 1;
    localparam longint unsigned DIST_NUM      = 1000;
    localparam longint unsigned DIST_DEN      = 58824;
    localparam int              SETTLE_CYCLES = 8;
    localparam int              PHASE_TICKS   = 80;
    localparam int              RAND_PHASES   = 5;
    localparam int              LONG_ECHO     = 100;
    localparam int              MAX_PRINTS    = 40;

    localparam cfg_t DEFAULT_CFG = '{
        trigger_period:   24'd100000,
        trigger_width:    8'd2,
        echo_timeout:     16'd40000,
        min_distance:     11'd2,
        limit_very_close: 11'd10,
        limit_close:      11'd25,
        limit_medium:     11'd40,
        alarm_step:       22'd50000
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [0] echo
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // [0] trigger, [1] alarm,
                                             // [12:2] distance_cm, [15:13] zone,
                                             // [16] new_measure
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bit          idle_on    = 1'b1;
    int          stall_left = 0;
    int unsigned tick_count = 0;
    int unsigned n_readings = 0;
    int unsigned n_settings = 0;
    int unsigned err_count  = 0;
    int unsigned zone_hits [5] = '{default: 0};

    res_t due_readings [$];

    // predictor state
    cfg_t             regs       = DEFAULT_CFG;
    logic [CNT_W-1:0] period_cnt = '0;
    logic [CNT_W-1:0] alarm_cnt  = '0;
    logic [7:0]       trig_left  = '0;
    logic             echo_prev  = 1'b0;
    logic             measuring  = 1'b0;
    logic [15:0]      echo_cnt   = '0;
    logic [10:0]      last_dist  = '0;
    zone_t            zone_now   = ZONE_UNDEF;
    logic             alarm_run  = 1'b0;
    logic             alarm_lvl  = 1'b1;

    ultrasonic_range_zone_alarm_unit #(
        .COUNT_BITS(CNT_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #5ns aclk = ~aclk;

    function automatic longint unsigned cnt_cap(input longint unsigned v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void close_reading(input logic [15:0] width);
        zone_t z;
        measuring = 1'b0;
        last_dist = 11'((64'(width) * DIST_NUM) / DIST_DEN);
        if (last_dist < regs.min_distance) begin
            z = ZONE_UNDEF;
        end else if (last_dist < regs.limit_very_close) begin
            z = ZONE_VERY_CLOSE;
        end else if (last_dist < regs.limit_close) begin
            z = ZONE_CLOSE;
        end else if (last_dist < regs.limit_medium) begin
            z = ZONE_MEDIUM;
        end else begin
            z = ZONE_FAR;
        end
        if (z != zone_now) begin
            zone_now = z;
            if (z == ZONE_UNDEF) begin
                alarm_run = 1'b0;
            end else begin
                alarm_run = 1'b1;
                alarm_cnt = '0;
            end
        end
    endfunction

    function automatic res_t sensor_tick(input logic echo);
        longint unsigned last_tick;
        longint unsigned half;
        logic            trig;
        logic            fresh;
        fresh = 1'b0;

        if (period_cnt == 0) trig_left = regs.trigger_width;
        trig = (trig_left != 0);
        if (trig_left != 0) trig_left = trig_left - 1'b1;
        last_tick = (regs.trigger_period == 0) ? 0 : cnt_cap(64'(regs.trigger_period) - 1);
        if (64'(period_cnt) >= last_tick) begin
            period_cnt = '0;
        end else begin
            period_cnt = period_cnt + 1'b1;
        end

        if (alarm_run && zone_now < ZONE_UNDEF) begin
            half = cnt_cap(64'(regs.alarm_step) * (64'd4 - 64'(zone_now)));
            alarm_cnt = alarm_cnt + 1'b1;
            if (64'(alarm_cnt) >= half) begin
                alarm_lvl = ~alarm_lvl;
                alarm_cnt = '0;
            end
        end

        if (measuring) begin
            if (!echo) begin
                close_reading(echo_cnt);
                fresh = 1'b1;
            end else if (echo_cnt != 16'hFFFF) begin
                echo_cnt = echo_cnt + 1'b1;
            end
        end else if (echo && !echo_prev) begin
            measuring = 1'b1;
            echo_cnt  = 16'd1;
        end
        if (measuring && echo_cnt >= regs.echo_timeout) begin
            echo_cnt = regs.echo_timeout;
            close_reading(echo_cnt);
            fresh = 1'b1;
        end
        echo_prev = echo;

        return '{new_measure: fresh, zone: zone_now, distance_cm: last_dist,
                 alarm: alarm_lvl, trigger: trig};
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    task automatic send_tick(input logic echo);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, echo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        due_readings.push_back(sensor_tick(echo));
        tick_count++;
        @(negedge aclk);
    endtask

    task automatic send_run(input logic echo, input int unsigned n);
        repeat (n) send_tick(echo);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_readings.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apply_cfg(input cfg_t c);
        reg_idx_t r;
        settle();
        r = r.first();
        repeat (r.num()) begin
            cfg_we  <= 1'b1;
            cfg_idx <= r;
            case (r)
                REG_TRIGGER_PERIOD:   cfg_wdata <= CFG_DATA_W'(c.trigger_period);
                REG_TRIGGER_WIDTH:    cfg_wdata <= CFG_DATA_W'(c.trigger_width);
                REG_ECHO_TIMEOUT:     cfg_wdata <= CFG_DATA_W'(c.echo_timeout);
                REG_MIN_DISTANCE:     cfg_wdata <= CFG_DATA_W'(c.min_distance);
                REG_LIMIT_VERY_CLOSE: cfg_wdata <= CFG_DATA_W'(c.limit_very_close);
                REG_LIMIT_CLOSE:      cfg_wdata <= CFG_DATA_W'(c.limit_close);
                REG_LIMIT_MEDIUM:     cfg_wdata <= CFG_DATA_W'(c.limit_medium);
                REG_ALARM_STEP:       cfg_wdata <= CFG_DATA_W'(c.alarm_step);
                default:              cfg_wdata <= '0;
            endcase
            @(negedge aclk);
            r = r.next();
        end
        cfg_we <= 1'b0;
        regs = c;
        n_settings++;
    endtask

    task automatic test_power_on();
        send_run(1'b0, 2);
        send_run(1'b1, 3);
        send_run(1'b0, 2);
    endtask

    task automatic test_corner_settings();
        // trigger every tick, zero timeout, zero alarm step
        apply_cfg('{trigger_period: 24'd0, trigger_width: 8'd3, echo_timeout: 16'd0,
                    min_distance: 11'd0, limit_very_close: 11'd1, limit_close: 11'd2,
                    limit_medium: 11'd3, alarm_step: 22'd0});
        send_tick(1'b0);
        send_run(1'b1, 2);
        send_tick(1'b0);
        send_tick(1'b1);

        // period of one, no trigger pulse, fall back into undefined zone
        apply_cfg('{trigger_period: 24'd1, trigger_width: 8'd0, echo_timeout: 16'd1,
                    min_distance: 11'd1, limit_very_close: 11'd2, limit_close: 11'd3,
                    limit_medium: 11'd4, alarm_step: 22'd1});
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // widest trigger, longest timeout, close zone
        apply_cfg('{trigger_period: 24'd3, trigger_width: 8'd255, echo_timeout: 16'hFFFF,
                    min_distance: 11'd0, limit_very_close: 11'd0, limit_close: 11'd1,
                    limit_medium: 11'd1114, alarm_step: 22'd2});
        send_tick(1'b0);
        send_run(1'b1, 3);
        send_tick(1'b0);

        // longest period and step, far zone, held echo after timeout
        apply_cfg('{trigger_period: 24'hFFFFFF, trigger_width: 8'd1, echo_timeout: 16'd2,
                    min_distance: 11'd0, limit_very_close: 11'd0, limit_close: 11'd0,
                    limit_medium: 11'd0, alarm_step: 22'h3FFFFF});
        send_run(1'b1, 3);
        send_tick(1'b0);
        send_tick(1'b1);

        // trigger width equal to period, medium zone
        apply_cfg('{trigger_period: 24'd5, trigger_width: 8'd5, echo_timeout: 16'd100,
                    min_distance: 11'd0, limit_very_close: 11'd0, limit_close: 11'd0,
                    limit_medium: 11'd1, alarm_step: 22'd1});
        send_tick(1'b0);
        send_tick(1'b1);
        send_run(1'b0, 4);
    endtask

    task automatic test_long_echo();
        cfg_t c;
        c = DEFAULT_CFG;
        c.trigger_period = 24'd16;
        c.echo_timeout   = 16'd90;
        c.alarm_step     = 22'd1;
        apply_cfg(c);
        idle_on = 1'b0;
        send_tick(1'b0);
        send_run(1'b1, LONG_ECHO);
        send_run(1'b0, 3);
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        cfg_t        c;
        int          sel;
        int unsigned stop_at;
        int unsigned hi_len;
        repeat (RAND_PHASES) begin
            sel = $urandom_range(0, 9);
            c.trigger_period = (sel < 3) ? 24'($urandom_range(0, 2)) :
                               (sel < 8) ? 24'($urandom_range(3, 64)) :
                                           24'($urandom_range(65, 24'hFFFFFF));
            c.trigger_width  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                                                             8'($urandom_range(0, 8));
            sel = $urandom_range(0, 9);
            c.echo_timeout   = (sel == 0) ? 16'd0 :
                               (sel == 1) ? 16'd1 :
                               (sel < 7)  ? 16'($urandom_range(2, 150)) :
                                            16'($urandom_range(151, 16'hFFFF));
            c.min_distance     = ($urandom_range(0, 9) == 0) ? 11'd1114 :
                                                               11'($urandom_range(0, 2));
            c.limit_very_close = ($urandom_range(0, 9) == 0) ? 11'd1114 :
                                                               11'($urandom_range(0, 4));
            c.limit_close      = ($urandom_range(0, 9) == 0) ? 11'd1114 :
                                                               11'($urandom_range(0, 4));
            c.limit_medium     = ($urandom_range(0, 9) == 0) ? 11'd1114 :
                                                               11'($urandom_range(0, 4));
            c.alarm_step       = ($urandom_range(0, 4) == 0) ?
                                 22'($urandom_range(0, 22'h3FFFFF)) :
                                 22'($urandom_range(0, 6));
            apply_cfg(c);

            stop_at = tick_count + PHASE_TICKS;
            while (tick_count < stop_at) begin
                idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
                end else begin
                    send_run(1'b0, $urandom_range(1, 8));
                    hi_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) :
                                                           $urandom_range(1, 40);
                    send_run(1'b1, hi_len);
                end
            end
        end
        idle_on = 1'b1;
    endtask

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[16:0];
            if (due_readings.size() == 0) begin
                report_mismatch("unrequested word", m_tdata, 0);
            end else begin
                want = due_readings.pop_front();
                if (got.trigger !== want.trigger)
                    report_mismatch("trigger", got.trigger, want.trigger);
                if (got.alarm !== want.alarm)
                    report_mismatch("alarm", got.alarm, want.alarm);
                if (got.distance_cm !== want.distance_cm)
                    report_mismatch("distance_cm", got.distance_cm, want.distance_cm);
                if (got.zone !== want.zone)
                    report_mismatch("zone", got.zone, want.zone);
                if (got.new_measure !== want.new_measure)
                    report_mismatch("new_measure", got.new_measure, want.new_measure);
                if (m_tdata[23:17] !== '0)
                    report_mismatch("pad bits", m_tdata[23:17], 0);
                zone_hits[want.zone]++;
                if (want.new_measure) n_readings++;
            end
        end
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_power_on();
        test_corner_settings();
        test_long_echo();
        test_random_traffic();
        settle();
        $display("Covered %0d echo ticks under %0d register settings, %0d range readings.",
                 tick_count, n_settings, n_readings);
        $display("Ticks per zone: far %0d, medium %0d, close %0d, very close %0d, undef %0d",
                 zone_hits[ZONE_FAR], zone_hits[ZONE_MEDIUM], zone_hits[ZONE_CLOSE],
                 zone_hits[ZONE_VERY_CLOSE], zone_hits[ZONE_UNDEF]);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
